@@ hdl/bns_pkg.sv @@
package bns_pkg;

  localparam int unsigned MaxNodes = 8;
  localparam int unsigned NodeW    = MaxNodes;
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned SuccW    = MaxNodes + 1;
  localparam int unsigned MaskW    = MaxNodes * MaxNodes;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_COUNT     = 2'd0,
    CFG_PARENT_MASKS   = 2'd1,
    CFG_POSITIVE_MASKS = 2'd2
  } cfg_reg_e;

  // Per-node outcome of the update rule, node j in bit j.
  typedef struct packed {
    logic [NodeW-1:0] unknown;
    logic [NodeW-1:0] value;
  } node_vec_t;

  // Clamp a written node count into 1..MaxNodes.
  function automatic logic [CntW-1:0] clamp_nodes(logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CntW'(1);
    end else if (v > CntW'(MaxNodes)) begin
      r = CntW'(MaxNodes);
    end
    return r;
  endfunction

endpackage

@@ hdl/bns_node_eval.sv @@
module bns_node_eval (
  input  logic [bns_pkg::NodeW-1:0] par_i,
  input  logic [bns_pkg::NodeW-1:0] pos_i,
  input  logic [bns_pkg::NodeW-1:0] ones_i,
  output logic                      known_o,
  output logic                      value_o
);
  import bns_pkg::*;

  logic [NodeW-1:0] neg;
  logic             all_on;
  logic             all_off;

  assign neg     = par_i & ~pos_i;
  // all_on: drives the node to 1, all_off: drives it to 0
  assign all_on  = ((ones_i & pos_i) == pos_i) && ((ones_i & neg) == '0);
  assign all_off = ((ones_i & pos_i) == '0) && ((ones_i & neg) == neg);
  assign known_o = (|par_i) && (all_on || all_off);
  assign value_o = (|par_i) && all_on;

endmodule

@@ hdl/bns_deposit.sv @@
module bns_deposit (
  input  bns_pkg::node_vec_t         nodes_i,
  input  logic [bns_pkg::CntW-1:0]   n_i,
  input  logic [bns_pkg::NodeW-1:0]  idx_i,
  output logic [bns_pkg::NodeW-1:0]  next_state_o,
  output logic [bns_pkg::SuccW-1:0]  count_o,
  output logic                       valid_o
);
  import bns_pkg::*;

  logic [CntW-1:0]  uc;
  logic [CntW-1:0]  rank;
  logic [CntW-1:0]  sel;
  logic [NodeW-1:0] node_val;

  always_comb begin
    uc = '0;
    for (int j = 0; j < MaxNodes; j++) begin
      uc = uc + CntW'(nodes_i.unknown[j]);
    end

    // Fill unknown nodes, lowest node first, with index bits taken MSB first.
    rank     = '0;
    sel      = '0;
    node_val = '0;
    for (int j = 0; j < MaxNodes; j++) begin
      if (nodes_i.unknown[j]) begin
        sel         = uc - CntW'(1) - rank;
        node_val[j] = idx_i[sel[$clog2(NodeW)-1:0]];
        rank        = rank + CntW'(1);
      end else begin
        node_val[j] = nodes_i.value[j];
      end
    end

    count_o     = '0;
    count_o[uc] = 1'b1;
    valid_o     = (idx_i >> uc) == '0;

    // Node k sits in state bit n-1-k.
    next_state_o = '0;
    for (int k = 0; k < MaxNodes; k++) begin
      sel = n_i - CntW'(1) - CntW'(k);
      if (valid_o && (CntW'(k) < n_i)) begin
        next_state_o[k] = node_val[sel[$clog2(NodeW)-1:0]];
      end
    end
  end

endmodule

@@ hdl/boolean_network_successor.sv @@
// Boolean network successor. Each beat on start_i carries a network state
// (node 0 in the most significant used bit) and an enumeration index. The
// block evaluates every node's next value from its configured parents and
// polarities, fills the nodes whose next value is unknown with the index bits
// (most significant first, lowest node first) and returns that successor,
// the number of successors and a flag telling whether the index was in range.
// Timing: a beat is taken in every cycle (busy_o stays low), and its result
// passes through the input register, then through the node evaluators and
// the deposit logic into the result register before it appears on done_o.
// The result is shown for one cycle only and cannot be stalled, so
// the receiver must take it when done_o is high. Program node_count,
// parent_masks and positive_masks through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while no beat is in flight; node counts of 0 read as 1 and above 8 as 8.
module boolean_network_successor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bns_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bns_pkg::MaskW-1:0]     cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bns_pkg::NodeW-1:0]     state_id_i,
  input  logic [bns_pkg::NodeW-1:0]     enum_index_i,
  output logic                          done_o,
  output logic [bns_pkg::NodeW-1:0]     next_state_o,
  output logic [bns_pkg::SuccW-1:0]     successor_count_o,
  output logic                          index_valid_o
);
  import bns_pkg::*;

  // Configuration registers; node count is held already clamped.
  logic [CntW-1:0]  n_q;
  logic [MaskW-1:0] par_q;
  logic [MaskW-1:0] pos_q;

  // Input register stage.
  logic             s1_valid_q;
  logic [NodeW-1:0] state_q;
  logic [NodeW-1:0] idx_q;

  // Result register stage.
  logic             done_q;
  logic [NodeW-1:0] next_state_q;
  logic [SuccW-1:0] count_q;
  logic             index_valid_q;

  logic             accept;
  logic [NodeW-1:0] used_mask;
  logic [NodeW-1:0] ones;
  node_vec_t        nodes;
  logic [NodeW-1:0] next_state_d;
  logic [SuccW-1:0] count_d;
  logic             index_valid_d;

  // Never stalls: a new beat is taken every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= CntW'(MaxNodes);
      par_q <= '0;
      pos_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_NODE_COUNT:     n_q   <= clamp_nodes(cfg_wdata_i[CntW-1:0]);
        CFG_PARENT_MASKS:   par_q <= cfg_wdata_i;
        CFG_POSITIVE_MASKS: pos_q <= cfg_wdata_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Capture the beat; payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      state_q <= state_id_i;
      idx_q   <= enum_index_i;
    end
  end

  // Node-indexed view of the current state: node i lives in bit n-1-i.
  always_comb begin
    logic [CntW-1:0] sel;
    used_mask = '0;
    ones      = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      sel = n_q - CntW'(1) - CntW'(i);
      if (CntW'(i) < n_q) begin
        used_mask[i] = 1'b1;
        ones[i]      = state_q[sel[$clog2(NodeW)-1:0]];
      end
    end
  end

  // One rule evaluator per node; nodes beyond the count take no part.
  for (genvar j = 0; j < MaxNodes; j++) begin : g_node
    logic [NodeW-1:0] par_j;
    logic [NodeW-1:0] pos_j;
    logic             known_j;
    logic             value_j;

    assign par_j = par_q[j*NodeW +: NodeW] & used_mask;
    assign pos_j = pos_q[j*NodeW +: NodeW] & par_j;

    bns_node_eval u_eval (
      .par_i   (par_j),
      .pos_i   (pos_j),
      .ones_i  (ones),
      .known_o (known_j),
      .value_o (value_j)
    );

    assign nodes.unknown[j] = used_mask[j] && !known_j;
    assign nodes.value[j]   = used_mask[j] && value_j;
  end

  bns_deposit u_deposit (
    .nodes_i      (nodes),
    .n_i          (n_q),
    .idx_i        (idx_q),
    .next_state_o (next_state_d),
    .count_o      (count_d),
    .valid_o      (index_valid_d)
  );

  // Result register: strobe for exactly one cycle per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      next_state_q  <= next_state_d;
      count_q       <= count_d;
      index_valid_q <= index_valid_d;
    end
  end

  assign done_o            = done_q;
  assign next_state_o      = next_state_q;
  assign successor_count_o = count_q;
  assign index_valid_o     = index_valid_q;

endmodule

@@ hdl/bns_checker.sv @@
module bns_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [bns_pkg::NodeW-1:0]     enum_index_i,
  input logic                          done_o,
  input logic [bns_pkg::NodeW-1:0]     next_state_o,
  input logic [bns_pkg::SuccW-1:0]     successor_count_o,
  input logic                          index_valid_o
);
  import bns_pkg::*;

  // Every accepted beat yields its result on done_o, via the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("accepted beat produced no result");

  // No result without an accepted beat in the matching earlier cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted beat");

  a_count_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot(successor_count_o))
    else $error("successor count is not a power of two");

  // Valid flag matches the beat's index; an invalid index gives a zero successor.
  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (index_valid_o == (SuccW'($past(enum_index_i, 2)) < successor_count_o))
               && (index_valid_o || (next_state_o == '0)))
    else $error("index_valid or zeroed successor inconsistent");

endmodule

bind boolean_network_successor bns_checker u_bns_checker (.*);

@@ tb/tb_boolean_network_successor.sv @@
`timescale 1ns / 100ps

module tb_boolean_network_successor;
  import bns_pkg::*;

  localparam int unsigned ClkHalf  = 6;
  localparam int unsigned DirRows  = 24;
  localparam int unsigned ItemGoal = 1450;
  localparam logic [MaskW-1:0] AllOnes = '1;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [NodeW-1:0] next_state;
    logic [SuccW-1:0] count;
    logic             valid;
  } succ_t;

  // One row of the directed table. Rows with reprogram set first drain the
  // block and load all three registers; rows with typed set carry the result
  // by hand instead of asking the predictor.
  typedef struct packed {
    logic             reprogram;
    logic [3:0]       nodes;
    logic [MaskW-1:0] parents;
    logic [MaskW-1:0] polarity;
    logic [NodeW-1:0] state_id;
    logic [NodeW-1:0] enum_index;
    logic             typed;
    logic [NodeW-1:0] want_next;
    logic [SuccW-1:0] want_count;
    logic             want_valid;
  } dir_row_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i    = CFG_NODE_COUNT;
  logic [MaskW-1:0]     cfg_wdata_i  = '0;
  logic                 start_i      = 1'b0;
  logic [NodeW-1:0]     state_id_i   = '0;
  logic [NodeW-1:0]     enum_index_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [NodeW-1:0]     next_state_o;
  logic [SuccW-1:0]     successor_count_o;
  logic                 index_valid_o;

  // Shadow copy of the network registers, reset values included.
  logic [3:0]       net_nodes    = 4'd8;
  logic [MaskW-1:0] net_parents  = '0;
  logic [MaskW-1:0] net_polarity = '0;

  succ_t       successor_q[$];
  int unsigned mismatch_count = 0;

  // Directed cases, most checked by hand: reset config, clamped node counts, saturated masks,
  // indexes past the successor count, ignored bits and bytes, self loops.
  dir_row_t directed_rows [DirRows] = '{
    // after reset: no parents, every node free, result is the index itself
    '{1'b0, 4'd0, '0, '0, 8'hA5, 8'h3C, 1'b1, 8'h3C, 9'd256, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'h00, 8'hFF, 1'b1, 8'hFF, 9'd256, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'h00, 1'b1, 8'h00, 9'd256, 1'b1},
    // node count 0 reads as one node: two successors, state bits ignored
    '{1'b1, 4'd0, '0, '0, 8'hFF, 8'h00, 1'b1, 8'h00, 9'd2, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'h01, 1'b1, 8'h01, 9'd2, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'h00, 8'h02, 1'b1, 8'h00, 9'd2, 1'b0},
    '{1'b0, 4'd0, '0, '0, 8'h00, 8'hFF, 1'b1, 8'h00, 9'd2, 1'b0},
    // count 15 clamps to 8; fully connected, all positive
    '{1'b1, 4'd15, AllOnes, AllOnes, 8'hFF, 8'h00, 1'b1, 8'hFF, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'h00, 8'h00, 1'b1, 8'h00, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'h01, 1'b1, 8'h00, 9'd1, 1'b0},
    '{1'b0, 4'd0, '0, '0, 8'h80, 8'h5A, 1'b1, 8'h5A, 9'd256, 1'b1},
    // fully connected, all negative
    '{1'b1, 4'd8, AllOnes, '0, 8'h00, 8'h00, 1'b1, 8'hFF, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'h00, 1'b1, 8'h00, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'h81, 8'hC3, 1'b1, 8'hC3, 9'd256, 1'b1},
    // count 9 clamps to 8, mixed masks
    '{1'b1, 4'd9, 64'h0123_4567_89AB_CDEF, 64'hF0F0_3C3C_AA55_0FF0,
      8'h5A, 8'h07, 1'b0, '0, '0, 1'b0},
    '{1'b0, 4'd0, '0, '0, 8'hC3, 8'h00, 1'b0, '0, '0, 1'b0},
    // four nodes: parents beyond the net, bytes of absent nodes and
    // polarity bits with no parent all present
    '{1'b1, 4'd4, 64'hDEAD_BEEF_F3A5_1C69, 64'h1234_5678_0F0F_F0F0,
      8'hF5, 8'h00, 1'b0, '0, '0, 1'b0},
    '{1'b0, 4'd0, '0, '0, 8'h0A, 8'h03, 1'b0, '0, '0, 1'b0},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0},
    // one node feeding itself, positive
    '{1'b1, 4'd1, 64'hFFFF_FFFF_FFFF_FF01, 64'h0000_0000_0000_0001,
      8'hFF, 8'h00, 1'b1, 8'h01, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFE, 8'h00, 1'b1, 8'h00, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'hFF, 8'h01, 1'b1, 8'h00, 9'd1, 1'b0},
    // one node feeding itself, negative
    '{1'b1, 4'd1, 64'h0000_0000_0000_0001, '0,
      8'h01, 8'h00, 1'b1, 8'h00, 9'd1, 1'b1},
    '{1'b0, 4'd0, '0, '0, 8'h00, 8'h00, 1'b1, 8'h01, 9'd1, 1'b1}
  };

  boolean_network_successor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .state_id_i       (state_id_i),
    .enum_index_i     (enum_index_i),
    .done_o           (done_o),
    .next_state_o     (next_state_o),
    .successor_count_o(successor_count_o),
    .index_valid_o    (index_valid_o)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // Work out the successor for one query under the shadow registers.
  // Nodes are indexed 0..n-1 here; node j lives in word bit n-1-j.
  function automatic succ_t enumerate_successor(logic [NodeW-1:0] st,
                                                logic [NodeW-1:0] ix);
    int unsigned n;
    int unsigned free_nodes;
    int unsigned taken;
    logic [NodeW-1:0] used;
    logic [NodeW-1:0] level;
    logic [NodeW-1:0] par;
    logic [NodeW-1:0] pos;
    logic [NodeW-1:0] neg;
    logic [NodeW-1:0] free;
    logic [NodeW-1:0] fixed_val;
    succ_t res;
    n = (net_nodes == 4'd0) ? 1 : ((net_nodes > 4'd8) ? 8 : int'(net_nodes));
    used = NodeW'((9'd1 << n) - 9'd1);
    level = '0;
    free = '0;
    fixed_val = '0;
    free_nodes = 0;
    for (int i = 0; i < n; i++) level[i] = st[n-1-i];
    for (int j = 0; j < n; j++) begin
      par = net_parents[8*j +: 8] & used;
      pos = net_polarity[8*j +: 8] & par;
      neg = par & ~pos;
      free[j] = 1'b1;
      if (par != '0) begin
        if ((level & pos) == pos && (level & neg) == '0) begin
          free[j] = 1'b0;
          fixed_val[j] = 1'b1;
        end else if ((level & pos) == '0 && (level & neg) == neg) begin
          free[j] = 1'b0;
        end
      end
      if (free[j]) free_nodes++;
    end
    res.count = SuccW'(1) << free_nodes;
    res.valid = (SuccW'(ix) < res.count);
    res.next_state = '0;
    if (res.valid) begin
      taken = 0;
      // deposit index bits, most significant first, into the free nodes
      for (int j = 0; j < n; j++) begin
        if (free[j]) begin
          res.next_state[n-1-j] = ix[free_nodes-1-taken];
          taken++;
        end else begin
          res.next_state[n-1-j] = fixed_val[j];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Present one query and hold it until the block takes it; the expectation
  // is queued at the accepting edge, under the config then in force.
  task automatic send_query(input logic [NodeW-1:0] st, input logic [NodeW-1:0] ix,
                            input logic typed, input succ_t want);
    start_i      <= 1'b1;
    state_id_i   <= st;
    enum_index_i <= ix;
    do @(posedge clk_i); while (busy_o);
    successor_q.insert(successor_q.size(), typed ? want : enumerate_successor(st, ix));
  endtask

  // Drop start and wait until every expected beat is back and the block is
  // idle, so a register write cannot touch a query in flight.
  task automatic settle();
    start_i <= 1'b0;
    while (successor_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [MaskW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_network(input logic [3:0] nodes, input logic [MaskW-1:0] parents,
                                 input logic [MaskW-1:0] polarity);
    write_reg(CFG_NODE_COUNT, MaskW'(nodes));
    net_nodes = nodes;
    write_reg(CFG_PARENT_MASKS, parents);
    net_parents = parents;
    write_reg(CFG_POSITIVE_MASKS, polarity);
    net_polarity = polarity;
    cfg_we_i <= 1'b0;
  endtask

  // Result checker: a beat on done_o is taken at the edge closing its cycle.
  always @(posedge clk_i) begin
    succ_t want;
    if (rst_ni && done_o) begin
      if (successor_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: next %0h count %0d",
                                  next_state_o, successor_count_o));
      end else begin
        want = successor_q.pop_front();
        if (next_state_o !== want.next_state)
          report_mismatch($sformatf("next_state got %0h want %0h",
                                    next_state_o, want.next_state));
        if (successor_count_o !== want.count)
          report_mismatch($sformatf("successor_count got %0d want %0d",
                                    successor_count_o, want.count));
        if (index_valid_o !== want.valid)
          report_mismatch($sformatf("index_valid got %0b want %0b",
                                    index_valid_o, want.valid));
      end
    end
  end

  // Stimulus: directed table, then random phases, each with its own network.
  initial begin
    dir_row_t         row;
    int unsigned      sent;
    int unsigned      phase_items;
    int unsigned      burst_left;
    int unsigned      guard;
    bit               gaps_on;
    logic [3:0]       nodes;
    logic [MaskW-1:0] parents;
    logic [MaskW-1:0] polarity;
    logic [NodeW-1:0] st;
    logic [NodeW-1:0] ix;
    succ_t            probe;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DirRows; k++) begin
      row = directed_rows[k];
      if (row.reprogram) begin
        settle();
        program_network(row.nodes, row.parents, row.polarity);
      end
      send_query(row.state_id, row.enum_index, row.typed,
                 '{row.want_next, row.want_count, row.want_valid});
    end

    sent = 0;
    while (sent < ItemGoal) begin
      settle();
      // mostly legal counts, now and then 0 or above eight to hit the clamp
      case ($urandom_range(0, 9))
        0:       nodes = 4'd0;
        1:       nodes = 4'($urandom_range(9, 15));
        2:       nodes = 4'd8;
        default: nodes = 4'($urandom_range(1, 8));
      endcase
      parents  = {$urandom, $urandom};
      polarity = {$urandom, $urandom};
      // sparse parent sets leave room for nodes whose next value is fixed
      case ($urandom_range(0, 4))
        0: parents = parents & {$urandom, $urandom} & {$urandom, $urandom};
        1: parents = parents & {$urandom, $urandom};
        2: parents = AllOnes;
        3: polarity = $urandom_range(0, 1) ? AllOnes : '0;
        default: ;
      endcase
      program_network(nodes, parents, polarity);

      phase_items = $urandom_range(60, 180);
      gaps_on     = ($urandom_range(0, 3) != 0);
      burst_left  = $urandom_range(1, 24);
      for (int i = 0; i < phase_items; i++) begin
        if (gaps_on && burst_left == 0) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
          burst_left = $urandom_range(1, 24);
        end
        st = NodeW'($urandom_range(0, 255));
        // the count does not hang on the index, so aim the index at it
        probe = enumerate_successor(st, '0);
        case ($urandom_range(0, 3))
          0:       ix = NodeW'($urandom_range(0, 255));
          1:       ix = (probe.count > 9'd255) ? 8'hFF : NodeW'(probe.count);
          2:       ix = NodeW'(probe.count - 9'd1);
          default: ix = NodeW'($urandom_range(0, int'(probe.count)));
        endcase
        send_query(st, ix, 1'b0, '0);
        sent++;
        if (burst_left != 0) burst_left--;
      end
    end

    start_i <= 1'b0;
    guard = 0;
    while (successor_q.size() != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (successor_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", successor_q.size()));

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(200000 * 2 * ClkHalf);
    $display("FAIL");
    $finish;
  end

endmodule
